@@ hw/rtl/qbp_pkg.sv @@
// Package for the quantise-and-bit-pack block: constants, payload and
// register structs shared by every module. No dependencies.
`default_nettype none

package qbp_pkg;

   localparam int MAX_CODE_WIDTH = 32;
   localparam int WIDTH_BITS     = 6;
   localparam int VALUE_BITS     = 48;
   localparam int SCALE_BITS     = 32;
   localparam int DIFF_BITS      = VALUE_BITS + 1;
   localparam int IP_BITS        = 50;
   localparam int ACC_BITS       = MAX_CODE_WIDTH + 8;
   localparam int CNT_BITS       = $clog2(ACC_BITS);
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int ADDR_BITS      = 5;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 6'd16;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 32'd65536;

   typedef enum logic [1:0] {
      REG_CODE_WIDTH = 2'd0,
      REG_REFERENCE  = 2'd1,
      REG_SCALE      = 2'd2,
      REG_UNUSED     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] sample;
      logic                         final_sample;
   } req_data_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       run_last;
      logic       stream_end;
      logic       code_clamped;
   } rsp_data_type;

   typedef struct packed {
      logic        [WIDTH_BITS-1:0] code_width;
      logic signed [VALUE_BITS-1:0] reference_value;
      logic        [SCALE_BITS-1:0] scale_factor;
   } cfg_type;

   // one quantised code on its way from the front to the packer
   typedef struct packed {
      logic [MAX_CODE_WIDTH-1:0] code;
      logic [WIDTH_BITS-1:0]     width;
      logic                      clamped;
      logic                      final_sample;
   } code_item_type;

endpackage

`default_nettype wire

@@ hw/rtl/qbp_csr.sv @@
// Configuration registers behind an APB-style port.
// Depends on qbp_pkg.
`default_nettype none

module qbp_csr import qbp_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [ADDR_BITS-1:0]     paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   cfg_type       cfg_ff;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[ADDR_BITS-1:3]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_width      <= WIDTH_RESET;
         cfg_ff.reference_value <= '0;
         cfg_ff.scale_factor    <= SCALE_RESET;
      end else if (wr_en) begin
         unique case (idx)
            REG_CODE_WIDTH: cfg_ff.code_width      <= pwdata[WIDTH_BITS-1:0];
            REG_REFERENCE:  cfg_ff.reference_value <= pwdata[VALUE_BITS-1:0];
            REG_SCALE:      cfg_ff.scale_factor    <= pwdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_CODE_WIDTH: prdata = CSR_DATA_BITS'(cfg_ff.code_width);
         REG_REFERENCE:  prdata = CSR_DATA_BITS'(unsigned'(cfg_ff.reference_value));
         REG_SCALE:      prdata = CSR_DATA_BITS'(cfg_ff.scale_factor);
         default:        prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/qbp_front.sv @@
// Front end: accepts samples and quantises them in a five-stage pipeline
// (subtract, magnitude, low product, high product, round and saturate).
// Depends on qbp_pkg.
`default_nettype none

module qbp_front import qbp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          push,
   output logic               full,
   input  wire req_data_type  req_data,
   input  wire logic          q_full,
   output logic               q_push,
   output code_item_type      q_data
);

   logic                      adv;
   logic [4:0]                valid_ff;

   logic [DIFF_BITS-1:0]      diff1_ff;
   logic [DIFF_BITS-1:0]      mag2_ff;
   logic [63:0]               lo3_ff;
   logic [DIFF_BITS-33:0]     mhi3_ff;
   logic [IP_BITS-1:0]        ip4_ff;
   logic                      rnd4_ff;
   code_item_type             out5_ff;

   logic [WIDTH_BITS-1:0]     w_ff [4];
   logic [3:0]                fin_ff;
   logic [3:1]                neg_ff;

   logic [DIFF_BITS-1:0]      diff1_in;
   logic [WIDTH_BITS-1:0]     w1_in;
   logic [63:0]               lo3_in;
   logic [IP_BITS-1:0]        ip4_in;
   logic [IP_BITS-1:0]        sum5;
   logic [MAX_CODE_WIDTH-1:0] maxc5;
   code_item_type             out5_in;

   assign adv    = ~(valid_ff[4] & q_full);
   assign full   = ~adv;
   assign q_push = valid_ff[4] & ~q_full;
   assign q_data = out5_ff;

   assign diff1_in = {req_data.sample[VALUE_BITS-1], req_data.sample}
                   - {cfg.reference_value[VALUE_BITS-1], cfg.reference_value};
   assign w1_in    = (cfg.code_width > WIDTH_BITS'(MAX_CODE_WIDTH))
                   ? WIDTH_BITS'(MAX_CODE_WIDTH) : cfg.code_width;
   assign lo3_in   = 64'(mag2_ff[31:0]) * 64'(cfg.scale_factor);
   assign ip4_in   = IP_BITS'(mhi3_ff) * IP_BITS'(cfg.scale_factor)
                   + IP_BITS'(lo3_ff[63:32]);

   always_comb begin
      sum5  = ip4_ff + IP_BITS'(rnd4_ff);
      maxc5 = MAX_CODE_WIDTH'((33'd1 << w_ff[3]) - 33'd1);
      out5_in.width        = w_ff[3];
      out5_in.final_sample = fin_ff[3];
      if (w_ff[3] == '0) begin
         out5_in.code    = '0;
         out5_in.clamped = 1'b0;
      end else if (neg_ff[3]) begin
         out5_in.code    = '0;
         out5_in.clamped = (sum5 >= IP_BITS'(2));
      end else if ((sum5 >> w_ff[3]) != '0) begin
         out5_in.code    = maxc5;
         out5_in.clamped = 1'b1;
      end else begin
         out5_in.code    = sum5[MAX_CODE_WIDTH-1:0];
         out5_in.clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], push};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff1_ff  <= diff1_in;
         w_ff[0]   <= w1_in;
         fin_ff[0] <= req_data.final_sample;

         neg_ff[1] <= diff1_ff[DIFF_BITS-1];
         mag2_ff   <= diff1_ff[DIFF_BITS-1] ? (~diff1_ff + DIFF_BITS'(1)) : diff1_ff;
         w_ff[1]   <= w_ff[0];
         fin_ff[1] <= fin_ff[0];

         lo3_ff    <= lo3_in;
         mhi3_ff   <= mag2_ff[DIFF_BITS-1:32];
         neg_ff[2] <= neg_ff[1];
         w_ff[2]   <= w_ff[1];
         fin_ff[2] <= fin_ff[1];

         ip4_ff    <= ip4_in;
         rnd4_ff   <= lo3_ff[31];
         neg_ff[3] <= neg_ff[2];
         w_ff[3]   <= w_ff[2];
         fin_ff[3] <= fin_ff[2];

         out5_ff   <= out5_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/qbp_fifo.sv @@
// Short queue of quantised codes between the front end and the packer.
// Depends on qbp_pkg.
`default_nettype none

module qbp_fifo import qbp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire code_item_type push_data,
   output logic               q_full,
   input  wire logic          pop,
   output logic               q_empty,
   output code_item_type      pop_data
);

   code_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS:0]   count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign q_full   = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign q_empty  = (count_ff == '0);
   assign do_push  = push & ~q_full;
   assign do_pop   = pop & ~q_empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         if (do_push & ~do_pop) begin
            count_ff <= count_ff + (QPTR_BITS+1)'(1);
         end else if (do_pop & ~do_push) begin
            count_ff <= count_ff - (QPTR_BITS+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

@@ hw/rtl/qbp_back.sv @@
// Back end: packs codes MSB-first into bytes, at most one byte per cycle while
// the result output register is free or being popped, with a flush on the final sample.
// Depends on qbp_pkg.
`default_nettype none

module qbp_back import qbp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_empty,
   input  wire code_item_type q_data,
   output logic               q_pop,
   output logic               empty,
   input  wire logic          pop,
   output rsp_data_type       rsp_data
);

   logic [ACC_BITS-1:0]       acc_ff;
   logic [CNT_BITS-1:0]       cnt_ff;
   logic                      busy_ff;
   logic                      fin_ff;
   logic                      clmp_ff;
   logic                      rsp_valid_ff;
   rsp_data_type              rsp_ff;

   logic                      full_byte;
   logic                      have;
   logic                      is_last;
   logic                      out_free;
   logic                      emit;
   logic                      done;
   logic                      load;
   logic [ACC_BITS-1:0]       acc_base;
   logic [CNT_BITS-1:0]       cnt_base;
   logic [MAX_CODE_WIDTH-1:0] code_left;
   logic [ACC_BITS-1:0]       new_bits;

   assign full_byte = (cnt_ff >= CNT_BITS'(8));
   assign have      = full_byte | (fin_ff & (cnt_ff != '0));
   assign is_last   = full_byte ? ((cnt_ff == CNT_BITS'(8))
                                   | ((cnt_ff < CNT_BITS'(16)) & ~fin_ff))
                                : 1'b1;
   assign out_free  = ~rsp_valid_ff | pop;
   assign emit      = busy_ff & have & out_free;
   assign done      = ~busy_ff | ~have | (emit & is_last);
   assign load      = done & ~q_empty;
   assign q_pop     = load;
   assign empty     = ~rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (emit) begin
         acc_base = full_byte ? (acc_ff << 8) : '0;
         cnt_base = full_byte ? (cnt_ff - CNT_BITS'(8)) : '0;
      end else begin
         acc_base = acc_ff;
         cnt_base = cnt_ff;
      end
      code_left = q_data.code << (WIDTH_BITS'(MAX_CODE_WIDTH) - q_data.width);
      new_bits  = {code_left, 8'h00} >> cnt_base[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         busy_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         clmp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            acc_ff  <= acc_base | new_bits;
            cnt_ff  <= cnt_base + CNT_BITS'(q_data.width);
            busy_ff <= 1'b1;
            fin_ff  <= q_data.final_sample;
            clmp_ff <= q_data.clamped;
         end else begin
            acc_ff  <= acc_base;
            cnt_ff  <= cnt_base;
            if (done) busy_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff.packed_byte  <= acc_ff[ACC_BITS-1 -: 8];
         rsp_ff.run_last     <= is_last;
         rsp_ff.stream_end   <= is_last & fin_ff;
         rsp_ff.code_clamped <= clmp_ff;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/quantize_and_bit_pack.sv @@
// Top level of the quantise-and-bit-pack block: register port, quantising
// front end, code queue and byte packer. Depends on qbp_pkg and all qbp_ modules.
//
// Each sample is turned into code = (sample - reference_value) * scale_factor
// / 2^32 + 0.5, truncated and saturated to code_width bits, and codes are
// packed MSB-first into bytes; a final sample flushes a partial byte padded
// with zeros. The front end takes one sample per cycle, unless a full queue
// stalls it, into a five-stage quantising pipeline and hands codes through a
// four-entry queue to the packer, which delivers at most one byte per cycle
// while its output register is free or being popped. The packer takes the
// next code in the same cycle as it emits the last byte of the current one.
// The user must write the configuration only while the block is idle; the
// block itself does not enforce this.
`default_nettype none

module quantize_and_bit_pack import qbp_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   output logic                          full,
   input  wire req_data_type             req_data,
   output logic                          empty,
   input  wire logic                     pop,
   output rsp_data_type                  rsp_data,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [ADDR_BITS-1:0]     paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   cfg_type       cfg;
   logic          q_full;
   logic          q_empty;
   logic          q_push;
   logic          q_pop;
   code_item_type q_in;
   code_item_type q_out;

   qbp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   qbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   qbp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .q_full    (q_full),
      .pop       (q_pop),
      .q_empty   (q_empty),
      .pop_data  (q_out)
   );

   qbp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_out),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
